### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros sample on clk and are quiet while rst_n is low.

// Implication checked in the same cycle.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Invariant checked on every rising clock edge.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant check failed");

`endif

### src/stm_pkg.sv
package stm_pkg;

  // default parameter values
  localparam int POS_BITS_DEF       = 32;
  localparam int PROFILE_PERIOD_DEF = 1000;
  localparam int MIN_STEP_IVL_DEF   = 50;

  // field widths
  localparam int CMD_W    = 4;
  localparam int TGT_W    = 32;
  localparam int SPD_W    = 24;
  localparam int MAXSPD_W = 23;
  localparam int ACC_W    = 20;
  localparam int PW_W     = 8;
  localparam int IVL_W    = 20;
  localparam int MODE_W   = 2;
  localparam int DV_W     = 22;
  localparam int CFG_W    = 32;
  localparam int PADDR_W  = 5;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE_TO  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE_REL = 4'd2;
  localparam logic [CMD_W-1:0] CMD_JOG      = 4'd3;
  localparam logic [CMD_W-1:0] CMD_STOP     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_ESTOP    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_SET_POS  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_ENABLE   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DISABLE  = 4'd8;

  // motion modes
  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POS  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_JOG  = 2'd2;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_MAX_SPEED = 3'd0;
  localparam logic [2:0] REG_ACCEL     = 3'd1;
  localparam logic [2:0] REG_MIN_LIMIT = 3'd2;
  localparam logic [2:0] REG_MAX_LIMIT = 3'd3;
  localparam logic [2:0] REG_SL_EN     = 3'd4;
  localparam logic [2:0] REG_DIR_INV   = 3'd5;
  localparam logic [2:0] REG_PULSE_W   = 3'd6;

  // speed thresholds, 1/256 step/s
  localparam logic [MAXSPD_W-1:0] STOP_THRESH = 23'd13;
  localparam logic [MAXSPD_W-1:0] MOVE_THRESH = 23'd3;
  localparam logic [MAXSPD_W-1:0] VMAX        = 23'h7FFFFF;

  // serial unit widths
  localparam int MUL_A_W  = 34;
  localparam int MUL_B_W  = 23;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W  = 42;
  localparam int DIV_D_W  = 23;
  localparam int SQ_IN_W  = 48;
  localparam int SQ_OUT_W = SQ_IN_W / 2;

  typedef struct packed {
    logic busy;
    logic done;
  } stm_unit_stat_t;

endpackage

### src/stepper_trapezoid_motion_controller_core.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------------------
// input     | in_valid / in_ready    | in_cmd, in_target_step, in_jog_speed
// result    | out_valid / out_ready  | out_step_level, out_dir_level, out_drive_enabled,
//           |                        | out_position, out_speed, out_motion_mode,
//           |                        | out_moving, out_target_unclamped
// config    | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// One transaction at a time. Commands and plain ticks pass from accept through the
// execute state (and, for an enabled tick, the step state) to the result load; a tick
// that runs the velocity profile (every PROFILE_PERIOD_US enabled ticks) also uses the
// bit-serial multiplier, divider and square root one after another, as its mode needs.
// A new input transaction is accepted while the previous result still waits in the
// output register; the sequencer stalls only at its final stage for that register.
// Reset is synchronous, active low; no clearing pass.
`include "assert_macros.svh"

module stepper_trapezoid_motion_controller_core #(
  parameter int PROFILE_PERIOD_US    = stm_pkg::PROFILE_PERIOD_DEF,
  parameter int MIN_STEP_INTERVAL_US = stm_pkg::MIN_STEP_IVL_DEF,
  parameter int POSITION_BITS        = stm_pkg::POS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [stm_pkg::CMD_W-1:0]     in_cmd,
  input  logic signed [stm_pkg::TGT_W-1:0] in_target_step,
  input  logic signed [stm_pkg::SPD_W-1:0] in_jog_speed,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_step_level,
  output logic                          out_dir_level,
  output logic                          out_drive_enabled,
  output logic signed [stm_pkg::TGT_W-1:0] out_position,
  output logic signed [stm_pkg::SPD_W-1:0] out_speed,
  output logic [stm_pkg::MODE_W-1:0]    out_motion_mode,
  output logic                          out_moving,
  output logic                          out_target_unclamped,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stm_pkg::PADDR_W-1:0]   paddr,
  input  logic [stm_pkg::CFG_W-1:0]     pwdata,
  output logic [stm_pkg::CFG_W-1:0]     prdata,
  output logic                          pready
);

  // position math width: wide enough for cur + delta and the limits without overflow
  localparam int CW    = ((POSITION_BITS > stm_pkg::TGT_W) ? POSITION_BITS : stm_pkg::TGT_W) + 2;
  localparam int SPW   = $clog2(PROFILE_PERIOD_US + 1);
  localparam int SPD_W = stm_pkg::SPD_W;
  localparam int DV_W  = stm_pkg::DV_W;
  localparam int IVL_W = stm_pkg::IVL_W;
  localparam logic [stm_pkg::MUL_A_W-1:0] DV_SCALE = stm_pkg::MUL_A_W'(256 * PROFILE_PERIOD_US);
  localparam logic [stm_pkg::DIV_D_W-1:0] DEN_US   = stm_pkg::DIV_D_W'(1000000);
  localparam logic [stm_pkg::DIV_D_W-1:0] DEN_PCT  = stm_pkg::DIV_D_W'(100);
  localparam logic [stm_pkg::DIV_N_W-1:0] IVL_NUM  = stm_pkg::DIV_N_W'(256000000);
  localparam logic [IVL_W-1:0]            MIN_IVL  = IVL_W'(MIN_STEP_INTERVAL_US);
  localparam logic [IVL_W-1:0]            IVL_RST  = IVL_W'(1000000);

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_DV_MUL, ST_DV_DIV, ST_POS_CHK, ST_LHS_MUL, ST_VSQ_MUL,
    ST_C_DIV, ST_SQRT, ST_RAMP, ST_JOG, ST_IVL, ST_IVL_DIV, ST_STEP, ST_DONE
  } state_t;

  // configuration
  logic [stm_pkg::MAXSPD_W-1:0]     max_speed_r;
  logic [stm_pkg::ACC_W-1:0]        accel_r;
  logic signed [stm_pkg::TGT_W-1:0] min_limit_r;
  logic signed [stm_pkg::TGT_W-1:0] max_limit_r;
  logic                             sl_en_r;
  logic                             dir_inv_r;
  logic [stm_pkg::PW_W-1:0]         pulse_width_r;

  // axis state
  state_t                           state_r;
  logic signed [POSITION_BITS-1:0]  cur_pos_r;
  logic signed [POSITION_BITS-1:0]  goal_pos_r;
  logic signed [SPD_W-1:0]          vel_r;
  logic signed [SPD_W-1:0]          jog_tgt_r;
  logic [stm_pkg::MODE_W-1:0]       mode_r;
  logic signed [1:0]                mdir_r;
  logic [IVL_W-1:0]                 ivl_r;
  logic [IVL_W-1:0]                 since_step_r;
  logic [SPW-1:0]                   since_prof_r;
  logic [stm_pkg::PW_W-1:0]         pulse_timer_r;
  logic                             pulse_high_r;
  logic                             en_r;
  logic                             dir_pin_r;

  // transaction and profile work registers
  logic [stm_pkg::CMD_W-1:0]        cmd_r;
  logic signed [stm_pkg::TGT_W-1:0] tgt_r;
  logic signed [SPD_W-1:0]          jog_in_r;
  logic                             unclamped_r;
  logic [DV_W-1:0]                  dv_r;
  logic                             rem_neg_r;
  logic [stm_pkg::MAXSPD_W-1:0]     desired_r;
  logic [53:0]                      lhs_r;
  logic [45:0]                      vsq_r;

  // serial unit ports
  logic                             mul_start_r;
  logic [stm_pkg::MUL_A_W-1:0]      mul_a_r;
  logic [stm_pkg::MUL_B_W-1:0]      mul_b_r;
  logic [stm_pkg::MUL_P_W-1:0]      mul_p;
  stm_pkg::stm_unit_stat_t          mul_stat;
  logic                             div_start_r;
  logic [stm_pkg::DIV_N_W-1:0]      div_num_r;
  logic [stm_pkg::DIV_D_W-1:0]      div_den_r;
  logic [stm_pkg::DIV_N_W-1:0]      div_q;
  stm_pkg::stm_unit_stat_t          div_stat;
  logic                             sqrt_start_r;
  logic [stm_pkg::SQ_IN_W-1:0]      sqrt_rad_r;
  logic [stm_pkg::SQ_OUT_W-1:0]     sqrt_root;
  stm_pkg::stm_unit_stat_t          sqrt_stat;

  // result register
  logic                             out_valid_r;
  logic                             out_step_r;
  logic                             out_dir_r;
  logic                             out_en_r;
  logic signed [stm_pkg::TGT_W-1:0] out_pos_r;
  logic signed [SPD_W-1:0]          out_spd_r;
  logic [stm_pkg::MODE_W-1:0]       out_mode_r;
  logic                             out_moving_r;
  logic                             out_unclamped_r;

  // combinational helpers
  logic signed [CW-1:0]             cur_x, goal_x, min_x, max_x, tgt_x;
  logic signed [CW-1:0]             mv_t, mv_c, rem_x, nxt_x;
  logic [CW-1:0]                    mag;
  logic [stm_pkg::MAXSPD_W-1:0]     va;
  logic [stm_pkg::ACC_W-1:0]        a_eff;
  logic [stm_pkg::ACC_W:0]          two_a;
  logic signed [SPD_W-1:0]          jog_c, jt, pos_t, ramp_t, ramp_v;
  logic signed [1:0]                ramp_dir;
  logic [46:0]                      x_sum;
  logic                             cfg_wr;

  function automatic logic signed [SPD_W-1:0] ramp_f(input logic signed [SPD_W-1:0] v,
                                                     input logic signed [SPD_W-1:0] t,
                                                     input logic [DV_W-1:0] dv);
    logic signed [SPD_W+1:0] n;
    n = (SPD_W+2)'(v);
    if (v < t) begin
      n = (SPD_W+2)'(v) + $signed({2'b00, (SPD_W)'(dv)});
      if (n > (SPD_W+2)'(t)) n = (SPD_W+2)'(t);
    end else if (v > t) begin
      n = (SPD_W+2)'(v) - $signed({2'b00, (SPD_W)'(dv)});
      if (n < (SPD_W+2)'(t)) n = (SPD_W+2)'(t);
    end
    return n[SPD_W-1:0];
  endfunction

  always_comb begin
    cur_x  = CW'(cur_pos_r);
    goal_x = CW'(goal_pos_r);
    min_x  = CW'(min_limit_r);
    max_x  = CW'(max_limit_r);
    tgt_x  = CW'(tgt_r);
    rem_x  = goal_x - cur_x;
    mag    = rem_x[CW-1] ? $unsigned(-rem_x) : $unsigned(rem_x);
    nxt_x  = cur_x + CW'(mdir_r);
    va     = vel_r[SPD_W-1] ? stm_pkg::MAXSPD_W'(-vel_r) : vel_r[stm_pkg::MAXSPD_W-1:0];
    a_eff  = (accel_r == '0) ? stm_pkg::ACC_W'(1) : accel_r;
    two_a  = {a_eff, 1'b0};
    x_sum  = 47'(vsq_r) + 47'(div_q[30:0]);

    // move target, clamped to the soft limits when they are enabled (min tested first)
    mv_t = (cmd_r == stm_pkg::CMD_MOVE_REL) ? (cur_x + tgt_x) : tgt_x;
    mv_c = mv_t;
    if (sl_en_r) begin
      if (mv_t < min_x) mv_c = min_x;
      else if (mv_t > max_x) mv_c = max_x;
    end

    // jog speed clamped to +/- max_speed
    jog_c = jog_in_r;
    if (jog_in_r > $signed({1'b0, max_speed_r})) jog_c = $signed({1'b0, max_speed_r});
    if (jog_in_r < -$signed({1'b0, max_speed_r})) jog_c = -$signed({1'b0, max_speed_r});

    // jog target zeroed when pushing into a limit (soft limits enabled)
    jt = jog_tgt_r;
    if (sl_en_r) begin
      if (cur_x >= max_x && jt > 0) jt = '0;
      if (cur_x <= min_x && jt < 0) jt = '0;
    end

    pos_t    = rem_neg_r ? -$signed({1'b0, desired_r}) : $signed({1'b0, desired_r});
    ramp_t   = (state_r == ST_JOG) ? jt : pos_t;
    ramp_v   = ramp_f(vel_r, ramp_t, dv_r);
    ramp_dir = (ramp_v > 0) ? 2'sd1 : ((ramp_v < 0) ? -2'sd1 : 2'sd0);
  end

  // configuration registers
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r   <= 23'd2560000;
      accel_r       <= 20'd20000;
      min_limit_r   <= -32'sd100000;
      max_limit_r   <= 32'sd100000;
      sl_en_r       <= 1'b1;
      dir_inv_r     <= 1'b0;
      pulse_width_r <= 8'd5;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        stm_pkg::REG_MAX_SPEED: max_speed_r   <= pwdata[stm_pkg::MAXSPD_W-1:0];
        stm_pkg::REG_ACCEL:     accel_r       <= pwdata[stm_pkg::ACC_W-1:0];
        stm_pkg::REG_MIN_LIMIT: min_limit_r   <= $signed(pwdata);
        stm_pkg::REG_MAX_LIMIT: max_limit_r   <= $signed(pwdata);
        stm_pkg::REG_SL_EN:     sl_en_r       <= pwdata[0];
        stm_pkg::REG_DIR_INV:   dir_inv_r     <= pwdata[0];
        stm_pkg::REG_PULSE_W:   pulse_width_r <= pwdata[stm_pkg::PW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      stm_pkg::REG_MAX_SPEED: prdata = 32'(max_speed_r);
      stm_pkg::REG_ACCEL:     prdata = 32'(accel_r);
      stm_pkg::REG_MIN_LIMIT: prdata = min_limit_r;
      stm_pkg::REG_MAX_LIMIT: prdata = max_limit_r;
      stm_pkg::REG_SL_EN:     prdata = 32'(sl_en_r);
      stm_pkg::REG_DIR_INV:   prdata = 32'(dir_inv_r);
      stm_pkg::REG_PULSE_W:   prdata = 32'(pulse_width_r);
      default:                prdata = '0;
    endcase
  end

  // shared bit-serial arithmetic
  stm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .p     (mul_p),
    .stat  (mul_stat)
  );

  stm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .q     (div_q),
    .stat  (div_stat)
  );

  stm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start_r),
    .rad   (sqrt_rad_r),
    .root  (sqrt_root),
    .stat  (sqrt_stat)
  );

  // sequencer: command execution, profile run, step generation, result load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cur_pos_r     <= '0;
      goal_pos_r    <= '0;
      vel_r         <= '0;
      jog_tgt_r     <= '0;
      mode_r        <= stm_pkg::MODE_IDLE;
      mdir_r        <= '0;
      ivl_r         <= IVL_RST;
      since_step_r  <= '0;
      since_prof_r  <= '0;
      pulse_timer_r <= '0;
      pulse_high_r  <= 1'b0;
      en_r          <= 1'b1;
      dir_pin_r     <= 1'b0;
      mul_start_r   <= 1'b0;
      div_start_r   <= 1'b0;
      sqrt_start_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      mul_start_r  <= 1'b0;
      div_start_r  <= 1'b0;
      sqrt_start_r <= 1'b0;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r       <= in_cmd;
            tgt_r       <= in_target_step;
            jog_in_r    <= in_jog_speed;
            unclamped_r <= 1'b0;
            state_r     <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          state_r <= ST_DONE;
          unique case (cmd_r)
            stm_pkg::CMD_TICK: begin
              if (en_r) begin
                if (since_step_r != '1) since_step_r <= since_step_r + 1'b1;
                if (pulse_timer_r != '1) pulse_timer_r <= pulse_timer_r + 1'b1;
                if (since_prof_r == SPW'(PROFILE_PERIOD_US - 1)) begin
                  since_prof_r <= '0;
                  if (mode_r == stm_pkg::MODE_IDLE) begin
                    state_r <= ST_IVL;
                  end else begin
                    // dv = a * 256 * period / 1e6
                    mul_a_r     <= DV_SCALE;
                    mul_b_r     <= stm_pkg::MUL_B_W'(a_eff);
                    mul_start_r <= 1'b1;
                    state_r     <= ST_DV_MUL;
                  end
                end else begin
                  since_prof_r <= since_prof_r + 1'b1;
                  state_r      <= ST_STEP;
                end
              end
            end
            stm_pkg::CMD_MOVE_TO, stm_pkg::CMD_MOVE_REL: begin
              en_r        <= 1'b1;
              goal_pos_r  <= mv_c[POSITION_BITS-1:0];
              mode_r      <= stm_pkg::MODE_POS;
              unclamped_r <= (mv_c == mv_t);
            end
            stm_pkg::CMD_JOG: begin
              en_r      <= 1'b1;
              jog_tgt_r <= jog_c;
              mode_r    <= (jog_c != 0 || vel_r != 0) ? stm_pkg::MODE_JOG : stm_pkg::MODE_IDLE;
            end
            stm_pkg::CMD_STOP: begin
              jog_tgt_r  <= '0;
              goal_pos_r <= cur_pos_r;
              mode_r     <= stm_pkg::MODE_JOG;
            end
            stm_pkg::CMD_ESTOP: begin
              vel_r        <= '0;
              jog_tgt_r    <= '0;
              goal_pos_r   <= cur_pos_r;
              mode_r       <= stm_pkg::MODE_IDLE;
              pulse_high_r <= 1'b0;
              en_r         <= 1'b0;
            end
            stm_pkg::CMD_SET_POS: begin
              cur_pos_r  <= tgt_x[POSITION_BITS-1:0];
              goal_pos_r <= tgt_x[POSITION_BITS-1:0];
              vel_r      <= '0;
              mode_r     <= stm_pkg::MODE_IDLE;
            end
            stm_pkg::CMD_ENABLE: en_r <= 1'b1;
            stm_pkg::CMD_DISABLE: begin
              en_r   <= 1'b0;
              mode_r <= stm_pkg::MODE_IDLE;
              vel_r  <= '0;
            end
            default: ;
          endcase
        end

        ST_DV_MUL: begin
          if (mul_stat.done) begin
            div_num_r   <= mul_p[stm_pkg::DIV_N_W-1:0];
            div_den_r   <= DEN_US;
            div_start_r <= 1'b1;
            state_r     <= ST_DV_DIV;
          end
        end

        ST_DV_DIV: begin
          if (div_stat.done) begin
            dv_r    <= (div_q == '0) ? DV_W'(1) : div_q[DV_W-1:0];
            state_r <= (mode_r == stm_pkg::MODE_POS) ? ST_POS_CHK : ST_JOG;
          end
        end

        ST_POS_CHK: begin
          if (rem_x == '0 && va < stm_pkg::STOP_THRESH) begin
            vel_r   <= '0;
            mdir_r  <= '0;
            mode_r  <= stm_pkg::MODE_IDLE;
            state_r <= ST_IVL;
          end else begin
            rem_neg_r <= rem_x[CW-1];
            desired_r <= max_speed_r;
            if (mag[CW-1:33] == '0) begin
              // lhs = |rem| * 2a
              mul_a_r     <= mag[stm_pkg::MUL_A_W-1:0];
              mul_b_r     <= stm_pkg::MUL_B_W'(two_a);
              mul_start_r <= 1'b1;
              state_r     <= ST_LHS_MUL;
            end else begin
              state_r <= ST_RAMP;
            end
          end
        end

        ST_LHS_MUL: begin
          if (mul_stat.done) begin
            lhs_r       <= mul_p[53:0];
            mul_a_r     <= stm_pkg::MUL_A_W'(va);
            mul_b_r     <= va;
            mul_start_r <= 1'b1;
            state_r     <= ST_VSQ_MUL;
          end
        end

        ST_VSQ_MUL: begin
          if (mul_stat.done) begin
            vsq_r       <= mul_p[45:0];
            div_num_r   <= stm_pkg::DIV_N_W'({two_a, 16'h0000});
            div_den_r   <= DEN_PCT;
            div_start_r <= 1'b1;
            state_r     <= ST_C_DIV;
          end
        end

        ST_C_DIV: begin
          if (div_stat.done) begin
            // braking once v^2 + margin covers 2a * remaining
            if (lhs_r <= 54'(x_sum[46:16])) begin
              sqrt_rad_r   <= {lhs_r[31:0], 16'h0000};
              sqrt_start_r <= 1'b1;
              state_r      <= ST_SQRT;
            end else begin
              state_r <= ST_RAMP;
            end
          end
        end

        ST_SQRT: begin
          if (sqrt_stat.done) begin
            desired_r <= sqrt_root[stm_pkg::SQ_OUT_W-1] ? stm_pkg::VMAX
                                                         : sqrt_root[stm_pkg::MAXSPD_W-1:0];
            state_r   <= ST_RAMP;
          end
        end

        ST_RAMP: begin
          vel_r   <= ramp_v;
          mdir_r  <= ramp_dir;
          state_r <= ST_IVL;
        end

        ST_JOG: begin
          jog_tgt_r <= jt;
          vel_r     <= ramp_v;
          if (ramp_v == 0 && jt == 0) begin
            mdir_r <= '0;
            mode_r <= stm_pkg::MODE_IDLE;
          end else begin
            mdir_r <= ramp_dir;
          end
          state_r <= ST_IVL;
        end

        ST_IVL: begin
          if (va >= stm_pkg::STOP_THRESH) begin
            div_num_r   <= IVL_NUM;
            div_den_r   <= va;
            div_start_r <= 1'b1;
            state_r     <= ST_IVL_DIV;
          end else begin
            state_r <= ST_STEP;
          end
        end

        ST_IVL_DIV: begin
          if (div_stat.done) begin
            if (div_q < stm_pkg::DIV_N_W'(MIN_IVL)) ivl_r <= MIN_IVL;
            else if (div_q > stm_pkg::DIV_N_W'({IVL_W{1'b1}})) ivl_r <= '1;
            else ivl_r <= div_q[IVL_W-1:0];
            state_r <= ST_STEP;
          end
        end

        ST_STEP: begin
          if (pulse_high_r && pulse_timer_r >= pulse_width_r) pulse_high_r <= 1'b0;
          if (mdir_r != 0 && va >= stm_pkg::STOP_THRESH && since_step_r >= ivl_r) begin
            since_step_r <= '0;
            dir_pin_r    <= (mdir_r > 0) ^ dir_inv_r;
            if (sl_en_r && ((mdir_r > 0 && nxt_x > max_x) || (mdir_r < 0 && nxt_x < min_x)))
            begin
              // step would leave the limits: halt
              vel_r  <= '0;
              mdir_r <= '0;
              mode_r <= stm_pkg::MODE_IDLE;
            end else begin
              pulse_high_r  <= 1'b1;
              pulse_timer_r <= '0;
              cur_pos_r     <= nxt_x[POSITION_BITS-1:0];
            end
          end
          state_r <= ST_DONE;
        end

        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r     <= 1'b1;
            out_step_r      <= pulse_high_r;
            out_dir_r       <= dir_pin_r;
            out_en_r        <= en_r;
            out_pos_r       <= cur_x[stm_pkg::TGT_W-1:0];
            out_spd_r       <= vel_r;
            out_mode_r      <= mode_r;
            out_moving_r    <= (mode_r != stm_pkg::MODE_IDLE) || (va >= stm_pkg::MOVE_THRESH);
            out_unclamped_r <= unclamped_r;
            state_r         <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready             = (state_r == ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_step_level       = out_step_r;
  assign out_dir_level        = out_dir_r;
  assign out_drive_enabled    = out_en_r;
  assign out_position         = out_pos_r;
  assign out_speed            = out_spd_r;
  assign out_motion_mode      = out_mode_r;
  assign out_moving           = out_moving_r;
  assign out_target_unclamped = out_unclamped_r;

  // a unit is only launched when all three are free
  `ASSERT_IMP(a_start_free, mul_start_r || div_start_r || sqrt_start_r,
              !mul_stat.busy && !div_stat.busy && !sqrt_stat.busy)
  // multiplier results only arrive while the sequencer waits on them
  `ASSERT_IMP(a_mul_done_wait, mul_stat.done,
              state_r == ST_DV_MUL || state_r == ST_LHS_MUL || state_r == ST_VSQ_MUL)
  // step interval never below the floor
  `ASSERT_ALWAYS(a_ivl_floor, ivl_r >= MIN_IVL)
  // velocity stays symmetric: the most negative code never appears
  `ASSERT_ALWAYS(a_vel_bound, vel_r != {1'b1, {(SPD_W-1){1'b0}}})

endmodule

### src/stm_mul.sv
module stm_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [stm_pkg::MUL_A_W-1:0]   a,
  input  logic [stm_pkg::MUL_B_W-1:0]   b,
  output logic [stm_pkg::MUL_P_W-1:0]   p,
  output stm_pkg::stm_unit_stat_t       stat
);

  localparam int CNT_W = $clog2(stm_pkg::MUL_B_W);

  logic [stm_pkg::MUL_P_W-1:0] acc_r;
  logic [stm_pkg::MUL_P_W-1:0] a_sh_r;
  logic [stm_pkg::MUL_B_W-1:0] b_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        acc_r  <= '0;
        a_sh_r <= stm_pkg::MUL_P_W'(a);
        b_r    <= b;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (b_r[0]) begin
          acc_r <= acc_r + a_sh_r;
        end
        a_sh_r <= a_sh_r << 1;
        b_r    <= b_r >> 1;
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(stm_pkg::MUL_B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign p         = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### src/stm_div.sv
module stm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [stm_pkg::DIV_N_W-1:0]   num,
  input  logic [stm_pkg::DIV_D_W-1:0]   den,
  output logic [stm_pkg::DIV_N_W-1:0]   q,
  output stm_pkg::stm_unit_stat_t       stat
);

  localparam int CNT_W = $clog2(stm_pkg::DIV_N_W);

  logic [stm_pkg::DIV_N_W-1:0] nq_r;   // numerator out at top, quotient in at bottom
  logic [stm_pkg::DIV_D_W-1:0] rem_r;
  logic [stm_pkg::DIV_D_W-1:0] den_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [stm_pkg::DIV_D_W:0]   rem_sh;
  logic                        fits;

  assign rem_sh = {rem_r, nq_r[stm_pkg::DIV_N_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_r});

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        nq_r   <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? stm_pkg::DIV_D_W'(rem_sh - {1'b0, den_r})
                      : rem_sh[stm_pkg::DIV_D_W-1:0];
        nq_r  <= {nq_r[stm_pkg::DIV_N_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(stm_pkg::DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign q         = nq_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### src/stm_sqrt.sv
module stm_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [stm_pkg::SQ_IN_W-1:0]    rad,
  output logic [stm_pkg::SQ_OUT_W-1:0]   root,
  output stm_pkg::stm_unit_stat_t        stat
);

  localparam int CNT_W = $clog2(stm_pkg::SQ_OUT_W);
  localparam int REM_W = stm_pkg::SQ_OUT_W + 2;

  logic [stm_pkg::SQ_IN_W-1:0]  rad_r;
  logic [stm_pkg::SQ_OUT_W-1:0] root_r;
  logic [REM_W-1:0]             rem_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [REM_W+1:0]             rem_sh;
  logic [REM_W+1:0]             trial;
  logic                         fits;

  assign rem_sh = {rem_r, rad_r[stm_pkg::SQ_IN_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  // digit-by-digit root, two radicand bits per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= rad;
        root_r <= '0;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= fits ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
        root_r <= {root_r[stm_pkg::SQ_OUT_W-2:0], fits};
        rad_r  <= rad_r << 2;
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(stm_pkg::SQ_OUT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
